// File: rtl/fuzzy_pd_controller_defines.svh
// Assertion macros for the fuzzy PD controller.
// No dependencies; included by the top level only.
`ifndef FUZZY_PD_CONTROLLER_DEFINES_SVH
`define FUZZY_PD_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define FPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define FPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fpd_pkg.sv
// Shared types, widths and constant tables of the fuzzy PD controller.
// No dependencies; imported by every module of the block.
package fpd_pkg;

   localparam int SETS        = 5;
   localparam int WEIGHT_BITS = 16;
   localparam int GAUSS_BITS  = 13;
   localparam logic [31:0] EXP_STEP = 32'd4278222805;

   localparam int SET_IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int CENTRE_W   = 17 + $clog2(SETS);
   localparam int ABS_W      = CENTRE_W;
   localparam int SQ_W       = 2 * ABS_W;
   localparam int PP_W       = ABS_W + 32;
   localparam int PROD_W     = SQ_W + 32;
   localparam int EXP_SHIFT  = 40;
   localparam int WEIGHT_W   = WEIGHT_BITS + 1;
   localparam int WEIGHT_ONE = 1 << WEIGHT_BITS;
   localparam int SUM_W      = WEIGHT_W + $clog2(SETS * SETS);
   localparam int PRODR_W    = SUM_W + 1 + CENTRE_W;
   localparam int NUM_W      = PRODR_W + $clog2(SETS);
   localparam int QUOT_BITS  = 17;
   localparam int DIV_W      = NUM_W + QUOT_BITS;

   localparam int LANE_LAT = 4 + GAUSS_BITS + 1;
   localparam int RULE_LAT = 4;
   localparam int DIV_LAT  = 1 + QUOT_BITS;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_FIRST_CENTER   = 3'd1,
      CSR_SPACING        = 3'd2,
      CSR_HALF_WIDTH     = 3'd3,
      CSR_INV_HALF_WIDTH = 3'd4,
      CSR_GAUSS_COEF     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               membership_mode;
      logic signed [15:0] first_center;
      logic [14:0]        center_spacing;
      logic [14:0]        half_width;
      logic [15:0]        inv_half_width;
      logic [31:0]        gauss_coef;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] error_in;
      logic signed [15:0] error_rate;
   } req_type;

   typedef struct packed {
      logic signed [15:0] correction;
      logic               no_activation;
   } rsp_type;

   typedef struct packed {
      logic [QUOT_BITS-1:0] quotient;
      logic                 negative;
      logic                 zero_sum;
   } div_result_type;

   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef weight_type [SETS-1:0]      weight_vec_type;
   typedef logic signed [CENTRE_W-1:0] centre_type;
   typedef centre_type [SETS-1:0]      centre_vec_type;
   typedef logic [GAUSS_BITS-1:0] [31:0] exp_table_type;

   // exp(-2^b/256) in Q0.32, each entry the rounded square of the one before
   function automatic exp_table_type exp_factors();
      exp_table_type t;
      logic [63:0]   c;
      c = {32'd0, EXP_STEP};
      for (int b = 0; b < GAUSS_BITS; b++) begin
         t[b] = c[31:0];
         c = (c * c + 64'h0000_0000_8000_0000) >> 32;
      end
      return t;
   endfunction

   localparam exp_table_type EXP_FACTORS = exp_factors();

   // Output set that rule (i, j) points at
   function automatic logic [SET_IDX_W-1:0] rule_out(input int i, input int j);
      int r;
      r = (SETS - 1) + (SETS - 1) / 2 - (i + j);
      if (r < 0) r = 0;
      if (r > SETS - 1) r = SETS - 1;
      return SET_IDX_W'(r);
   endfunction

endpackage

// File: rtl/fpd_member_lane.sv
// Membership pipeline for one input against one set centre.
// Depends on fpd_pkg; triangular and Gaussian paths run side by side.
module fpd_member_lane
   import fpd_pkg::*;
(
   input  logic               clock,
   input  logic               adv,
   input  cfg_type            cfg,
   input  centre_type         centre,
   input  logic signed [15:0] x,
   output weight_type         weight
);

   localparam logic [64:0] ROUND_HALF = 65'h0_8000_0000;
   localparam logic [32:0] W_ONE      = 33'h1_0000_0000;

   logic signed [CENTRE_W:0] diff;
   logic [ABS_W-1:0] abs_in, abs_ff;
   logic [SQ_W-1:0]  sq_in, sq_ff;
   logic [30:0]      tri_prod_in, tri_prod_ff;
   logic             tri_far_in, tri_far_ff;
   logic [PP_W-1:0]  p_lo_in, p_lo_ff, p_hi_in, p_hi_ff;
   logic [30:0]      ratio;
   weight_type       tri_w_in, tri_w_ff, tri4_ff;
   logic [PROD_W-1:0] full;
   logic [GAUSS_BITS-1:0] u_in, u_ff;
   logic             far_in, far_ff;
   weight_type       weight_in, weight_ff;

   logic [32:0]           st_w   [GAUSS_BITS];
   logic [GAUSS_BITS-1:0] st_u   [GAUSS_BITS];
   logic                  st_far [GAUSS_BITS];
   weight_type            st_tri [GAUSS_BITS];
   logic [32:0]           chain_w_in   [GAUSS_BITS];
   logic [32:0]           chain_w_ff   [GAUSS_BITS];
   logic [GAUSS_BITS-1:0] chain_u_ff   [GAUSS_BITS];
   logic                  chain_far_ff [GAUSS_BITS];
   weight_type            chain_tri_ff [GAUSS_BITS];

   // distance to the centre
   always_comb begin
      diff = $signed({{(CENTRE_W + 1 - 16){x[15]}}, x})
           - $signed({centre[CENTRE_W-1], centre});
      abs_in = diff[CENTRE_W] ? ABS_W'(-diff) : ABS_W'(diff);
   end

   always_comb begin
      sq_in       = SQ_W'(abs_ff) * SQ_W'(abs_ff);
      tri_prod_in = 31'(abs_ff[14:0]) * 31'(cfg.inv_half_width);
      tri_far_in  = abs_ff >= ABS_W'(cfg.half_width);
   end

   always_comb begin
      p_lo_in = PP_W'(sq_ff[ABS_W-1:0]) * PP_W'(cfg.gauss_coef);
      p_hi_in = PP_W'(sq_ff[SQ_W-1:ABS_W]) * PP_W'(cfg.gauss_coef);
      ratio   = tri_prod_ff >> (24 - WEIGHT_BITS);
      if (tri_far_ff || ratio >= 31'(WEIGHT_ONE)) begin
         tri_w_in = '0;
      end else begin
         tri_w_in = WEIGHT_W'(31'(WEIGHT_ONE) - ratio);
      end
   end

   always_comb begin
      full   = (PROD_W'(p_hi_ff) << ABS_W) + PROD_W'(p_lo_ff);
      u_in   = full[EXP_SHIFT+GAUSS_BITS-1:EXP_SHIFT];
      far_in = |full[PROD_W-1:EXP_SHIFT+GAUSS_BITS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         abs_ff      <= abs_in;
         sq_ff       <= sq_in;
         tri_prod_ff <= tri_prod_in;
         tri_far_ff  <= tri_far_in;
         p_lo_ff     <= p_lo_in;
         p_hi_ff     <= p_hi_in;
         tri_w_ff    <= tri_w_in;
         u_ff        <= u_in;
         far_ff      <= far_in;
         tri4_ff     <= tri_w_ff;
      end
   end

   // one rounded multiply per stage, one exponent bit each
   for (genvar b = 0; b < GAUSS_BITS; b++) begin : g_exp
      if (b == 0) begin : g_first
         assign st_w[b]   = W_ONE;
         assign st_u[b]   = u_ff;
         assign st_far[b] = far_ff;
         assign st_tri[b] = tri4_ff;
      end else begin : g_next
         assign st_w[b]   = chain_w_ff[b-1];
         assign st_u[b]   = chain_u_ff[b-1];
         assign st_far[b] = chain_far_ff[b-1];
         assign st_tri[b] = chain_tri_ff[b-1];
      end

      always_comb begin
         logic [64:0] prod;
         prod = 65'(st_w[b]) * 65'(EXP_FACTORS[b]) + ROUND_HALF;
         chain_w_in[b] = st_u[b][b] ? prod[64:32] : st_w[b];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            chain_w_ff[b]   <= chain_w_in[b];
            chain_u_ff[b]   <= st_u[b];
            chain_far_ff[b] <= st_far[b];
            chain_tri_ff[b] <= st_tri[b];
         end
      end
   end

   always_comb begin
      if (cfg.membership_mode) begin
         weight_in = chain_far_ff[GAUSS_BITS-1] ? '0
                   : chain_w_ff[GAUSS_BITS-1][32 -: WEIGHT_W];
      end else begin
         weight_in = chain_tri_ff[GAUSS_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

// File: rtl/fpd_rule_sum.sv
// Rule evaluation and weighted centre sum of the fuzzy PD controller.
// Depends on fpd_pkg; four register stages.
module fpd_rule_sum
   import fpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     adv,
   input  centre_vec_type           centres,
   input  weight_vec_type           we,
   input  weight_vec_type           wd,
   output logic signed [NUM_W-1:0]  num,
   output logic [SUM_W-1:0]         sum
);

   weight_type                min_in [SETS][SETS];
   weight_type                min_ff [SETS][SETS];
   logic [SUM_W-1:0]          bucket_in [SETS];
   logic [SUM_W-1:0]          bucket_ff [SETS];
   logic signed [PRODR_W-1:0] prod_in [SETS];
   logic signed [PRODR_W-1:0] prod_ff [SETS];
   logic [SUM_W-1:0]          total_in, total_ff;
   logic signed [NUM_W-1:0]   num_in, num_ff;
   logic [SUM_W-1:0]          sum_ff;

   always_comb begin
      for (int i = 0; i < SETS; i++) begin
         for (int j = 0; j < SETS; j++) begin
            min_in[i][j] = (we[i] < wd[j]) ? we[i] : wd[j];
         end
      end
   end

   // collect rule weights by output set
   always_comb begin
      for (int r = 0; r < SETS; r++) begin
         bucket_in[r] = '0;
      end
      for (int i = 0; i < SETS; i++) begin
         for (int j = 0; j < SETS; j++) begin
            bucket_in[rule_out(i, j)] = bucket_in[rule_out(i, j)] + SUM_W'(min_ff[i][j]);
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int r = 0; r < SETS; r++) begin
         prod_in[r] = $signed({1'b0, bucket_ff[r]}) * $signed(centres[r]);
         total_in   = total_in + bucket_ff[r];
      end
   end

   always_comb begin
      num_in = '0;
      for (int r = 0; r < SETS; r++) begin
         num_in = num_in + NUM_W'(prod_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         min_ff    <= min_in;
         bucket_ff <= bucket_in;
         prod_ff   <= prod_in;
         total_ff  <= total_in;
         num_ff    <= num_in;
         sum_ff    <= total_ff;
      end
   end

   assign num = num_ff;
   assign sum = sum_ff;

endmodule

// File: rtl/fpd_divider.sv
// Pipelined rounding divider: one quotient bit per stage.
// Depends on fpd_pkg; quotient saturates at its full width.
module fpd_divider
   import fpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [NUM_W-1:0] num,
   input  logic [SUM_W-1:0]        sum,
   output div_result_type          res
);

   logic [NUM_W-1:0] mag_in;
   logic [DIV_W-1:0] n_in, rem0_ff;
   logic             sat_in, sat0_ff, neg0_ff, zero0_ff;
   logic [SUM_W-1:0] den0_ff;

   logic [DIV_W-1:0]     st_rem [QUOT_BITS];
   logic [SUM_W-1:0]     st_den [QUOT_BITS];
   logic [QUOT_BITS-1:0] st_q   [QUOT_BITS];
   logic [2:0]           st_fl  [QUOT_BITS];
   logic [DIV_W-1:0]     rem_in [QUOT_BITS];
   logic [QUOT_BITS-1:0] q_in   [QUOT_BITS];
   logic [DIV_W-1:0]     rem_ff [QUOT_BITS];
   logic [SUM_W-1:0]     den_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS];
   logic [2:0]           fl_ff  [QUOT_BITS];

   // add half the divisor, check for overflow of the quotient
   always_comb begin
      mag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      n_in   = DIV_W'(mag_in) + DIV_W'(sum >> 1);
      sat_in = n_in >= (DIV_W'(sum) << QUOT_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem0_ff  <= n_in;
         den0_ff  <= sum;
         sat0_ff  <= sat_in;
         neg0_ff  <= num[NUM_W-1];
         zero0_ff <= (sum == '0);
      end
   end

   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_bit
      localparam int K = QUOT_BITS - 1 - s;
      if (s == 0) begin : g_first
         assign st_rem[s] = rem0_ff;
         assign st_den[s] = den0_ff;
         assign st_q[s]   = '0;
         assign st_fl[s]  = {sat0_ff, neg0_ff, zero0_ff};
      end else begin : g_next
         assign st_rem[s] = rem_ff[s-1];
         assign st_den[s] = den_ff[s-1];
         assign st_q[s]   = q_ff[s-1];
         assign st_fl[s]  = fl_ff[s-1];
      end

      always_comb begin
         logic [DIV_W-1:0] trial;
         trial = DIV_W'(st_den[s]) << K;
         rem_in[s] = st_rem[s];
         q_in[s]   = st_q[s];
         if (st_rem[s] >= trial) begin
            rem_in[s]  = st_rem[s] - trial;
            q_in[s][K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= st_den[s];
            q_ff[s]   <= q_in[s];
            fl_ff[s]  <= st_fl[s];
         end
      end
   end

   always_comb begin
      res.quotient = fl_ff[QUOT_BITS-1][2] ? {QUOT_BITS{1'b1}} : q_ff[QUOT_BITS-1];
      res.negative = fl_ff[QUOT_BITS-1][1];
      res.zero_sum = fl_ff[QUOT_BITS-1][0];
   end

endmodule

// File: rtl/fuzzy_pd_controller.sv
// Fuzzy PD controller top level: registers, lanes, rule sum, divider.
// Depends on fpd_pkg, fpd_member_lane, fpd_rule_sum, fpd_divider and the defines header.
//
//   Channel | Direction | Handshake          | Item
//   req_    | in        | req_valid/req_stall | req_type  (error_in, error_rate)
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_type  (correction, no_activation)
//   csr_    | in        | csr_we              | index 0..5, 32-bit data
//
// One item enters per clock while req_stall is low; the pipeline holds the 13 rounded
// multiplies of the Gaussian chain and the 17 quotient bits of the divider.
// Reset is synchronous: it empties the pipeline and loads the register defaults.
// A stalled result at the output freezes every stage at once and raises req_stall in the same cycle.
`include "fuzzy_pd_controller_defines.svh"

module fuzzy_pd_controller
   import fpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int LAT = LANE_LAT + RULE_LAT + DIV_LAT + 1;

   cfg_type         cfg_in, cfg_ff;
   logic            adv;
   logic [LAT-1:0]  valid_in, valid_ff;
   centre_vec_type  centres;
   weight_vec_type  we, wd;
   logic signed [NUM_W-1:0] num;
   logic [SUM_W-1:0]        sum;
   div_result_type  div_res;
   rsp_type         rsp_in, rsp_ff;

   // register writes: unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:           cfg_in.membership_mode = csr_wdata[0];
            CSR_FIRST_CENTER:   cfg_in.first_center    = $signed(csr_wdata[15:0]);
            CSR_SPACING:        cfg_in.center_spacing  = csr_wdata[14:0];
            CSR_HALF_WIDTH:     cfg_in.half_width      = csr_wdata[14:0];
            CSR_INV_HALF_WIDTH: cfg_in.inv_half_width  = csr_wdata[15:0];
            CSR_GAUSS_COEF:     cfg_in.gauss_coef      = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.membership_mode <= 1'b0;
         cfg_ff.first_center    <= -16'sd10240;
         cfg_ff.center_spacing  <= 15'd5120;
         cfg_ff.half_width      <= 15'd5120;
         cfg_ff.inv_half_width  <= 16'd3277;
         cfg_ff.gauss_coef      <= 32'd5368709;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // set centres follow the registers; user changes them only while idle, unenforced
   always_comb begin
      for (int k = 0; k < SETS; k++) begin
         centres[k] = $signed({{(CENTRE_W - 16){cfg_ff.first_center[15]}},
                               cfg_ff.first_center})
                    + $signed({{(CENTRE_W - 15){1'b0}}, cfg_ff.center_spacing})
                      * $signed(CENTRE_W'(k));
      end
   end

   // advance the whole pipeline unless a finished item is held at the output
   assign adv       = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;

   assign valid_in = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   for (genvar k = 0; k < SETS; k++) begin : g_lane
      fpd_member_lane u_err_lane (
         .clock  (clock),
         .adv    (adv),
         .cfg    (cfg_ff),
         .centre (centres[k]),
         .x      (req_payload.error_in),
         .weight (we[k])
      );

      fpd_member_lane u_rate_lane (
         .clock  (clock),
         .adv    (adv),
         .cfg    (cfg_ff),
         .centre (centres[k]),
         .x      (req_payload.error_rate),
         .weight (wd[k])
      );
   end

   fpd_rule_sum u_rule_sum (
      .clock   (clock),
      .adv     (adv),
      .centres (centres),
      .we      (we),
      .wd      (wd),
      .num     (num),
      .sum     (sum)
   );

   fpd_divider u_divider (
      .clock (clock),
      .adv   (adv),
      .num   (num),
      .sum   (sum),
      .res   (div_res)
   );

   // sign, saturate, and flag an empty rule base
   always_comb begin
      rsp_in.no_activation = 1'b0;
      priority if (div_res.zero_sum) begin
         rsp_in.correction    = '0;
         rsp_in.no_activation = 1'b1;
      end else if (div_res.negative) begin
         if (div_res.quotient >= QUOT_BITS'(32768)) begin
            rsp_in.correction = -16'sd32768;
         end else begin
            rsp_in.correction = -$signed(div_res.quotient[15:0]);
         end
      end else begin
         if (div_res.quotient >= QUOT_BITS'(32767)) begin
            rsp_in.correction = 16'sd32767;
         end else begin
            rsp_in.correction = $signed(div_res.quotient[15:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff[LAT-1];
   assign rsp_payload = rsp_ff;

   `FPD_ASSERT_IMP(a_no_act_zero, clock, reset, rsp_valid && rsp_payload.no_activation, rsp_payload.correction == 16'sd0, "no_activation with nonzero correction")
   `FPD_ASSERT_NXT(a_freeze_holds, clock, reset, !adv, $stable(valid_ff), "valid chain moved while frozen")
   `FPD_ASSERT_NXT(a_bubble_enters, clock, reset, adv && !req_valid, !valid_ff[0], "bubble lost at pipeline entry")

endmodule
